[hdl/kth_smallest_max_heap_macros.svh]
// ----------------------------------------------------------------------------
// kth_smallest_max_heap_macros
// assertion macros used by the checker file ksmh_checker
// ----------------------------------------------------------------------------
`ifndef KTH_SMALLEST_MAX_HEAP_MACROS_SVH
`define KTH_SMALLEST_MAX_HEAP_MACROS_SVH

// same-cycle implication
`define KSMH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KSMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ksmh_pkg.sv]
// ----------------------------------------------------------------------------
// ksmh_pkg
// constants, types and helpers for the k-th smallest selection block
// ----------------------------------------------------------------------------
package ksmh_pkg;

    localparam int MAX_K      = 16;
    localparam int VALUE_BITS = 32;
    localparam int FIELD_BITS = 32;
    localparam int RANK_W     = 5;
    localparam int FILL_W     = $clog2(MAX_K + 1);
    localparam int IDX_W      = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CHILD_W    = IDX_W + 2;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [FILL_W-1:0]     fill_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CHILD_W-1:0]    child_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_READ,
        ST_UP_CMP,
        ST_DOWN_READ,
        ST_DOWN_CMP,
        ST_PLACE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_children;
        logic move_up;
        logic move_down;
        logic place;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic insert;
        logic replace;
        logic fill_empty;
        logic up_go;
        logic parent_root;
        logic has_child;
        logic down_go;
        logic is_last;
        logic out_free;
    } dp_status_t;

    function automatic logic greater(input value_t a, input value_t b);
        greater = $signed(a) > $signed(b);
    endfunction

    function automatic fill_t effective_k(input logic [RANK_W-1:0] rank);
        fill_t k;
        if (rank == '0) begin
            k = fill_t'(1);
        end else if (int'(rank) > MAX_K) begin
            k = fill_t'(MAX_K);
        end else begin
            k = fill_t'(rank);
        end
        effective_k = k;
    endfunction

endpackage

[hdl/ksmh_ram.sv]
// ----------------------------------------------------------------------------
// ksmh_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module ksmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_a,
    output logic [WIDTH-1:0] rd_data_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

[hdl/ksmh_ctrl.sv]
// ----------------------------------------------------------------------------
// ksmh_ctrl
// sequencer for heap insert, replace and result delivery
// ----------------------------------------------------------------------------
module ksmh_ctrl import ksmh_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (status.insert) begin
                        state_next = status.fill_empty ? ST_PLACE : ST_UP_READ;
                    end else if (status.replace) begin
                        state_next = ST_DOWN_READ;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_UP_READ: begin
                state_next = ST_UP_CMP;
            end
            ST_UP_CMP: begin
                if (status.up_go) begin
                    state_next = status.parent_root ? ST_PLACE : ST_UP_READ;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_DOWN_READ: begin
                state_next = status.has_child ? ST_DOWN_CMP : ST_FINISH;
            end
            ST_DOWN_CMP: begin
                state_next = status.down_go ? ST_DOWN_READ : ST_FINISH;
            end
            ST_PLACE: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!status.is_last || status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_UP_READ: begin
                cmd.rd_children = 1'b0;
            end
            ST_UP_CMP: begin
                cmd.move_up = status.up_go;
                cmd.place   = !status.up_go;
            end
            ST_DOWN_READ: begin
                cmd.rd_children = status.has_child;
                cmd.place       = !status.has_child;
            end
            ST_DOWN_CMP: begin
                cmd.move_down = status.down_go;
                cmd.place     = !status.down_go;
            end
            ST_PLACE: begin
                cmd.place = 1'b1;
            end
            ST_FINISH: begin
                cmd.emit = status.is_last && status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[hdl/ksmh_dp.sv]
// ----------------------------------------------------------------------------
// ksmh_dp
// heap datapath: heap ram, position and fill tracking, rank and output regs
// ----------------------------------------------------------------------------
module ksmh_dp import ksmh_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [RANK_W-1:0]            cfg_wr_data,
    input  logic signed [FIELD_BITS-1:0] s_value,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [FIELD_BITS-1:0] m_kth_value,
    output logic                         m_not_present,
    input  ctrl_cmd_t                    cmd,
    output dp_status_t                   status
);

    logic [RANK_W-1:0]     rank_reg;
    fill_t                 fill_reg, fill_next;
    idx_t                  pos_reg, pos_next;
    value_t                cur_reg, cur_next;
    value_t                root_reg, root_next;
    logic                  last_reg, last_next;
    logic                  m_valid_reg, m_valid_next;
    logic [FIELD_BITS-1:0] kth_reg, kth_next;
    logic                  np_reg, np_next;

    fill_t  k_eff;
    value_t in_ext;
    idx_t   parent_idx;
    child_t child_l, child_r, child_sel;
    value_t rd_a, rd_b, child_val;
    logic   pick_right;
    logic   ram_we;
    value_t ram_wdata;
    idx_t   ram_raddr_a;
    logic   not_present;

    assign k_eff      = effective_k(rank_reg);
    assign in_ext     = value_t'(s_value);
    assign parent_idx = idx_t'((pos_reg - 1'b1) >> 1);
    assign child_l    = child_t'({pos_reg, 1'b1});
    assign child_r    = child_t'({pos_reg, 1'b0}) + child_t'(2);
    assign pick_right = (child_r < child_t'(fill_reg)) && greater(rd_b, rd_a);
    assign child_sel  = pick_right ? child_r : child_l;
    assign child_val  = pick_right ? rd_b : rd_a;
    assign not_present = fill_reg < k_eff;

    assign ram_raddr_a = cmd.rd_children ? child_l[IDX_W-1:0] : parent_idx;
    assign ram_we      = cmd.move_up || cmd.move_down || cmd.place;

    always_comb begin
        if (cmd.move_up) begin
            ram_wdata = rd_a;
        end else if (cmd.move_down) begin
            ram_wdata = child_val;
        end else begin
            ram_wdata = cur_reg;
        end
    end

    ksmh_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_K)
    ) u_heap_ram (
        .aclk      (aclk),
        .wr_en     (ram_we),
        .wr_addr   (pos_reg),
        .wr_data   (ram_wdata),
        .rd_addr_a (ram_raddr_a),
        .rd_data_a (rd_a),
        .rd_addr_b (child_r[IDX_W-1:0]),
        .rd_data_b (rd_b)
    );

    always_comb begin
        status.insert      = fill_reg < k_eff;
        status.replace     = (fill_reg != '0) && greater(root_reg, in_ext);
        status.fill_empty  = fill_reg == '0;
        status.up_go       = greater(cur_reg, rd_a);
        status.parent_root = parent_idx == '0;
        status.has_child   = child_l < child_t'(fill_reg);
        status.down_go     = greater(child_val, cur_reg);
        status.is_last     = last_reg;
        status.out_free    = !m_valid_reg || m_ready;
    end

    always_comb begin
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        cur_next     = cur_reg;
        last_next    = last_reg;
        root_next    = root_reg;
        m_valid_next = m_valid_reg && !m_ready;
        kth_next     = kth_reg;
        np_next      = np_reg;

        if (cmd.load) begin
            cur_next  = in_ext;
            last_next = s_last;
            if (status.insert) begin
                pos_next  = fill_reg[IDX_W-1:0];
                fill_next = fill_reg + 1'b1;
            end else begin
                pos_next = '0;
            end
        end
        if (cmd.move_up) begin
            pos_next = parent_idx;
        end
        if (cmd.move_down) begin
            pos_next = child_sel[IDX_W-1:0];
        end
        if (ram_we && pos_reg == '0) begin
            root_next = ram_wdata;
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            np_next      = not_present;
            kth_next     = not_present ? '0 : FIELD_BITS'(root_reg);
            fill_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg    <= RANK_W'(1);
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                rank_reg <= cfg_wr_data;
            end
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        cur_reg  <= cur_next;
        last_reg <= last_next;
        root_reg <= root_next;
        kth_reg  <= kth_next;
        np_reg   <= np_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_kth_value   = kth_reg;
    assign m_not_present = np_reg;

endmodule

[hdl/kth_smallest_max_heap.sv]
// ----------------------------------------------------------------------------
// kth_smallest_max_heap
// k-th smallest value of each set, kept in a bounded max-heap
//
//   channel   ports                          request
//   s_        s_valid s_ready                value, last flag
//   m_        m_valid m_ready                kth value, not-present flag
//   cfg_      cfg_wr_en                      rank k
//
// the sift loop handles each heap level in a ram read state followed by a
// compare/write state, on the single-write, dual-read heap ram
// reset clears fill, rank (to 1) and the output valid flag; the heap ram is
// not cleared and needs no clearing pass
// a last item waits in its final cycle while the output register is still full
// ----------------------------------------------------------------------------
module kth_smallest_max_heap import ksmh_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [RANK_W-1:0]            cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [FIELD_BITS-1:0] s_value,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [FIELD_BITS-1:0] m_kth_value,
    output logic                         m_not_present
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    ksmh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ksmh_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_value       (s_value),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kth_value   (m_kth_value),
        .m_not_present (m_not_present),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

[hdl/ksmh_checker.sv]
// ----------------------------------------------------------------------------
// ksmh_checker
// port-level checks on the k-th smallest selection block
// ----------------------------------------------------------------------------
`include "kth_smallest_max_heap_macros.svh"

module ksmh_checker import ksmh_pkg::*; (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [FIELD_BITS-1:0] m_kth_value,
    input logic                         m_not_present
);

    // stalled result holds
`KSMH_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_kth_value) && $stable(m_not_present), "stalled result changed")

    // missing rank reports zero
`KSMH_ASSERT_SAME(a_np_zero, aclk, aresetn, m_valid && m_not_present, m_kth_value == '0, "not-present result with nonzero value")

    // busy after taking a request
`KSMH_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "ready right after an accepted request")

    // a new result only follows a busy cycle
`KSMH_ASSERT_SAME(a_result_after_work, aclk, aresetn, $rose(m_valid), !$past(s_ready), "result appeared without work")

endmodule

bind kth_smallest_max_heap ksmh_checker u_ksmh_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for kth_smallest_max_heap: streams signed sets through
// the request channel under several rank settings, predicts the k-th smallest
// value of each set with a software max-heap and checks every result in order
// ----------------------------------------------------------------------------
module tb;
    import ksmh_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_ITEMS   = 850;
    localparam int SETTLE         = 16;

    localparam logic [FIELD_BITS-1:0] VAL_MIN = {1'b1, {(FIELD_BITS-1){1'b0}}};
    localparam logic [FIELD_BITS-1:0] VAL_MAX = {1'b0, {(FIELD_BITS-1){1'b1}}};

    class kth_scoreboard;
        typedef struct {
            value_t kth;
            logic   absent;
        } kth_result_t;

        value_t            heap[MAX_K];
        int                fill;
        logic [RANK_W-1:0] rank;
        kth_result_t       expected_kth[$];
        int                mismatches;

        function new();
            fill       = 0;
            rank       = 1;
            mismatches = 0;
        endfunction

        function void set_rank(logic [RANK_W-1:0] r);
            rank = r;
        endfunction

        function int effective_rank(logic [RANK_W-1:0] r);
            if (r == 0) begin
                return 1;
            end else if (int'(r) > MAX_K) begin
                return MAX_K;
            end
            return int'(r);
        endfunction

        function void take_value(value_t v, logic last);
            int          k;
            int          pos;
            int          parent;
            int          child;
            value_t      t;
            kth_result_t r;
            k = effective_rank(rank);
            if (fill < k) begin
                heap[fill] = v;
                pos = fill;
                fill++;
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (!($signed(heap[pos]) > $signed(heap[parent]))) break;
                    t = heap[pos];
                    heap[pos] = heap[parent];
                    heap[parent] = t;
                    pos = parent;
                end
            end else if (fill > 0 && $signed(heap[0]) > $signed(v)) begin
                heap[0] = v;
                pos = 0;
                while (2 * pos + 1 < fill) begin
                    child = 2 * pos + 1;
                    if (child + 1 < fill && $signed(heap[child + 1]) > $signed(heap[child]))
                        child = child + 1;
                    if (!($signed(heap[child]) > $signed(heap[pos]))) break;
                    t = heap[pos];
                    heap[pos] = heap[child];
                    heap[child] = t;
                    pos = child;
                end
            end
            if (last) begin
                if (fill < k) begin
                    r.kth    = '0;
                    r.absent = 1'b1;
                end else begin
                    r.kth    = heap[0];
                    r.absent = 1'b0;
                end
                expected_kth.push_back(r);
                fill = 0;
            end
        endfunction

        function void check_kth(value_t kth, logic absent);
            kth_result_t want;
            if (expected_kth.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kth_value %0d not_present %0b",
                             $signed(kth), absent);
                return;
            end
            want = expected_kth.pop_front();
            if (kth !== want.kth || absent !== want.absent) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected kth_value %0d not_present %0b, got %0d %0b",
                             $signed(want.kth), want.absent, $signed(kth), absent);
            end
        endfunction
    endclass

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [RANK_W-1:0]            cfg_wr_data;
    logic                         s_valid;
    logic                         s_ready;
    logic signed [FIELD_BITS-1:0] s_value;
    logic                         s_last;
    logic                         m_valid;
    logic                         m_ready;
    logic signed [FIELD_BITS-1:0] m_kth_value;
    logic                         m_not_present;

    kth_scoreboard board = new();

    int idle_pct       = 0;
    bit long_hold_due  = 1'b0;
    bit long_hold_done = 1'b0;
    int ready_gap      = 0;
    int quiet_cycles   = 0;

    always #1 aclk = ~aclk;

    kth_smallest_max_heap dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kth_value   (m_kth_value),
        .m_not_present (m_not_present)
    );

    task automatic send_item(input value_t v, input logic last);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        s_last  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.take_value(v, last);
    endtask

    task automatic write_rank(input logic [RANK_W-1:0] r);
        s_valid <= 1'b0;
        while (board.expected_kth.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.set_rank(r);
    endtask

    function automatic value_t pick_value(input int mode);
        case (mode)
            0: return value_t'($urandom);
            1: return value_t'($urandom_range(0, 15)) - value_t'(8);
            default: begin
                case ($urandom_range(0, 4))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return '0;
                    3: return '1;
                    default: return value_t'($urandom);
                endcase
            end
        endcase
    endfunction

    // result side: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_kth(m_kth_value, m_not_present);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap = ready_gap - 1;
            m_ready <= 1'b0;
        end else if (long_hold_due && !long_hold_done) begin
            long_hold_done = 1'b1;
            ready_gap = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            ready_gap = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[kth_smallest_max_heap] ERROR");
            $finish;
        end
    end

    initial begin
        logic [RANK_W-1:0] r;
        int                k;
        int                len;
        int                mode;
        int                sent;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_value     <= '0;
        s_last      <= 1'b0;
        m_ready     <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes, equal values, too few elements
        write_rank(5'd3);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item('0, 1'b0);
        send_item('1, 1'b0);
        send_item(value_t'(5), 1'b1);
        repeat (3) send_item(value_t'(7), 1'b0);
        send_item(value_t'(7), 1'b1);
        send_item(value_t'(1), 1'b0);
        send_item(value_t'(2), 1'b1);
        send_item(value_t'(9), 1'b1);
        // rank zero acts as one
        write_rank(5'd0);
        send_item(value_t'(5), 1'b0);
        send_item(-value_t'(3), 1'b1);
        send_item(VAL_MIN, 1'b1);
        // rank above the heap size saturates
        write_rank(5'd31);
        send_item(value_t'(30), 1'b0);
        send_item(value_t'(20), 1'b0);
        send_item(value_t'(10), 1'b1);
        write_rank(5'd1);
        send_item(value_t'(100), 1'b0);
        send_item(-value_t'(100), 1'b0);
        send_item(VAL_MAX, 1'b1);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0: r = 5'd0;
                1: r = 5'd1;
                2: r = 5'd16;
                3: r = 5'd31;
                4: r = RANK_W'($urandom_range(17, 30));
                default: r = RANK_W'($urandom_range(2, 15));
            endcase
            write_rank(r);
            k = board.effective_rank(r);
            if (sent > RANDOM_ITEMS * 4 / 5) begin
                idle_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 20;
                    default: idle_pct = 50;
                endcase
            end
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 5))
                    0: len = k;
                    1: len = (k > 1) ? k - 1 : 1;
                    2: len = 1;
                    default: len = $urandom_range(1, 2 * k + 8);
                endcase
                mode = $urandom_range(0, 2);
                for (int i = 0; i < len; i++) begin
                    send_item(pick_value(mode), (i == len - 1));
                    sent++;
                end
                if (sent > 250)
                    long_hold_due = 1'b1;
            end
        end
        s_valid <= 1'b0;

        while (board.expected_kth.size() != 0) @(posedge aclk);
        repeat (SETTLE + 8) @(posedge aclk);
        if (board.mismatches == 0 && board.expected_kth.size() == 0) begin
            $display("[kth_smallest_max_heap] OK");
        end else begin
            $display("[kth_smallest_max_heap] ERROR");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/ksmh_pkg.sv
hdl/ksmh_ram.sv
hdl/ksmh_ctrl.sv
hdl/ksmh_dp.sv
hdl/kth_smallest_max_heap.sv
hdl/ksmh_checker.sv
tb/sv/tb.sv
